/* hw/rtl/sm3_hash_core_defines.svh */
// ---------------------------------------------------------------------------
// SM3 hash core assertion macros
// Shared property shorthands for the SM3 hash core modules.
// ---------------------------------------------------------------------------
`ifndef SM3_HASH_CORE_DEFINES_SVH
`define SM3_HASH_CORE_DEFINES_SVH

// same-cycle implication
`define SM3_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define SM3_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/sm3_pkg.sv */
// ---------------------------------------------------------------------------
// SM3 package
// Constants, types and helper functions shared by the SM3 hash core.
// ---------------------------------------------------------------------------
package sm3_pkg;

   localparam logic [255:0] IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   localparam logic [31:0] T_LOW       = 32'h79CC4519;
   // 0x7A879D8A rotated left by 16, round constant at round 16
   localparam logic [31:0] T_HIGH_R16  = 32'h9D8A7A87;
   localparam logic [5:0]  T_SWITCH    = 6'd15;
   localparam logic [5:0]  LAST_ROUND  = 6'd63;
   localparam logic [7:0]  PAD_MARK    = 8'h80;
   localparam logic [5:0]  LEN_OFFSET  = 6'd56;
   localparam logic [2:0]  MAX_BYTES   = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } comp_status_type;

   function automatic logic [31:0] rotl32(logic [31:0] x, int n);
      rotl32 = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] perm0(logic [31:0] x);
      perm0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
   endfunction

   function automatic logic [31:0] perm1(logic [31:0] x);
      perm1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
   endfunction

   // shift nb bytes (0..8) from the top of src into the block, oldest byte on top
   function automatic logic [511:0] blk_append(logic [511:0] blk, logic [63:0] src,
                                               logic [3:0] nb);
      case (nb)
         4'd1: blk_append = {blk[503:0], src[63:56]};
         4'd2: blk_append = {blk[495:0], src[63:48]};
         4'd3: blk_append = {blk[487:0], src[63:40]};
         4'd4: blk_append = {blk[479:0], src[63:32]};
         4'd5: blk_append = {blk[471:0], src[63:24]};
         4'd6: blk_append = {blk[463:0], src[63:16]};
         4'd7: blk_append = {blk[455:0], src[63:8]};
         4'd8: blk_append = {blk[447:0], src[63:0]};
         default: blk_append = blk;
      endcase
   endfunction

endpackage

/* hw/rtl/sm3_comp.sv */
// ---------------------------------------------------------------------------
// SM3 compression unit
// One round per cycle; message expansion runs in a
// 16-word window alongside the rounds.
// ---------------------------------------------------------------------------
`include "sm3_hash_core_defines.svh"

module sm3_comp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [511:0]             block,
   input  logic [255:0]             cv,
   output logic [255:0]             cv_next,
   output sm3_pkg::comp_status_type status
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   logic [15:0][31:0] w_ff, w_in;

   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew;

   always_comb begin
      a12  = sm3_pkg::rotl32(a_ff, 12);
      ss1  = sm3_pkg::rotl32(a12 + e_ff + t_ff, 7);
      ss2  = ss1 ^ a12;
      if (round_ff[5:4] == 2'b00) begin
         ffv = a_ff ^ b_ff ^ c_ff;
         ggv = e_ff ^ f_ff ^ g_ff;
      end else begin
         ffv = (a_ff & b_ff) | (a_ff & c_ff) | (b_ff & c_ff);
         ggv = (e_ff & f_ff) | (~e_ff & g_ff);
      end
      tt1  = ffv + d_ff + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2  = ggv + h_ff + ss1 + w_ff[0];
      wnew = sm3_pkg::perm1(w_ff[0] ^ w_ff[7] ^ sm3_pkg::rotl32(w_ff[13], 15))
             ^ sm3_pkg::rotl32(w_ff[3], 7) ^ w_ff[10];
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      t_in     = t_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      e_in = e_ff; f_in = f_ff; g_in = g_ff; h_in = h_ff;
      w_in = w_ff;
      if (start) begin
         run_in   = 1'b1;
         round_in = '0;
         t_in     = sm3_pkg::T_LOW;
         a_in = cv[255:224]; b_in = cv[223:192]; c_in = cv[191:160]; d_in = cv[159:128];
         e_in = cv[127:96];  f_in = cv[95:64];   g_in = cv[63:32];   h_in = cv[31:0];
         for (int i = 0; i < 16; i++) begin
            w_in[i] = block[511 - 32 * i -: 32];
         end
      end else if (run_ff) begin
         d_in = c_ff; c_in = sm3_pkg::rotl32(b_ff, 9); b_in = a_ff; a_in = tt1;
         h_in = g_ff; g_in = sm3_pkg::rotl32(f_ff, 19); f_in = e_ff;
         e_in = sm3_pkg::perm0(tt2);
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = wnew;
         t_in     = (round_ff == sm3_pkg::T_SWITCH) ? sm3_pkg::T_HIGH_R16
                                                     : sm3_pkg::rotl32(t_ff, 1);
         round_in = round_ff + 6'd1;
         if (round_ff == sm3_pkg::LAST_ROUND) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      t_ff <= t_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      e_ff <= e_in; f_ff <= f_in; g_ff <= g_in; h_ff <= h_in;
      w_ff <= w_in;
   end

   assign cv_next     = cv ^ {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff};
   assign status.busy = run_ff;
   assign status.done = done_ff;

   `SM3_ASSERT_IMPL(a_start_when_idle, start, !run_ff, "start while compressing")
   `SM3_ASSERT_NEXT(a_start_runs, start, run_ff && round_ff == 6'd0, "start did not launch")
   `SM3_ASSERT_NEXT(a_last_round_done, run_ff && round_ff == sm3_pkg::LAST_ROUND, done_ff && !run_ff, "no done after last round")
   `SM3_ASSERT_IMPL(a_done_not_busy, done_ff, !run_ff, "done while running")

endmodule

/* hw/rtl/sm3_hash_core.sv */
// ---------------------------------------------------------------------------
// SM3 hash core
// Streaming SM3 hasher: byte-packed words in, 256-bit digest out per message.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  data_word, byte_count, last
//  rsp_      out        rsp_valid / rsp_stall  digest_0 .. digest_3
//
//  A word that does not fill the block is appended to the buffer directly.
//  A full block starts a compression; spilled bytes are appended in ST_TAIL.
//  A last item is followed by the pad mark, zero fill, the length field,
//  one or two block compressions and the digest load.
//  Synchronous reset restores the initial value and empties the buffer.
//  rsp_stall holds the digest; a following message waits only at its own end.
// ---------------------------------------------------------------------------
`include "sm3_hash_core_defines.svh"

module sm3_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_0,
   output logic [63:0] rsp_digest_1,
   output logic [63:0] rsp_digest_2,
   output logic [63:0] rsp_digest_3
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAIL,
      ST_MARK,
      ST_PAD,
      ST_COMP,
      ST_EMIT
   } state_type;

   state_type    state_ff, state_in;
   state_type    ret_ff, ret_in;
   logic [511:0] block_ff, block_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  total_ff, total_in;
   logic [31:0]  pend_ff, pend_in;
   logic [2:0]   rem_ff, rem_in;
   logic         last_ff, last_in;
   logic [255:0] cv_ff, cv_in;
   logic         start_ff, start_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [255:0] digest_ff, digest_in;

   logic [63:0]  src;
   logic [3:0]   nb;
   logic [2:0]   cnt, k3;
   logic [6:0]   room7, sum7;
   logic [5:0]   gap6;
   logic [255:0] comp_cv;
   sm3_pkg::comp_status_type comp_stat;

   sm3_comp u_comp (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .block   (block_ff),
      .cv      (cv_ff),
      .cv_next (comp_cv),
      .status  (comp_stat)
   );

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;
      cv_in        = cv_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      digest_in    = digest_ff;
      src          = '0;
      nb           = '0;
      cnt          = (req_byte_count > sm3_pkg::MAX_BYTES) ? sm3_pkg::MAX_BYTES
                                                          : req_byte_count;
      room7        = 7'd64 - {1'b0, fill_ff};
      k3           = ({4'b0, cnt} > room7) ? room7[2:0] : cnt;
      sum7         = '0;
      gap6         = sm3_pkg::LEN_OFFSET - fill_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               src      = {req_data_word, 32'b0};
               nb       = {1'b0, k3};
               sum7     = {1'b0, fill_ff} + {4'b0, k3};
               fill_in  = sum7[5:0];
               total_in = total_ff + {58'b0, cnt};
               pend_in  = req_data_word << {k3, 3'b000};
               rem_in   = cnt - k3;
               last_in  = req_last;
               if (sum7[6]) begin
                  state_in = ST_COMP;
                  start_in = 1'b1;
                  if (cnt != k3) begin
                     ret_in = ST_TAIL;
                  end else begin
                     ret_in = req_last ? ST_MARK : ST_IDLE;
                  end
               end else begin
                  state_in = req_last ? ST_MARK : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            src      = {pend_ff, 32'b0};
            nb       = {1'b0, rem_ff};
            fill_in  = fill_ff + {3'b0, rem_ff};
            state_in = last_ff ? ST_MARK : ST_IDLE;
         end
         ST_MARK: begin
            src     = {sm3_pkg::PAD_MARK, 56'b0};
            nb      = 4'd1;
            sum7    = {1'b0, fill_ff} + 7'd1;
            fill_in = sum7[5:0];
            if (sum7[6]) begin
               state_in = ST_COMP;
               start_in = 1'b1;
               ret_in   = ST_PAD;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (fill_ff == sm3_pkg::LEN_OFFSET) begin
               src      = {total_ff, 3'b000};
               nb       = 4'd8;
               fill_in  = '0;
               state_in = ST_COMP;
               start_in = 1'b1;
               ret_in   = ST_EMIT;
            end else if (fill_ff < sm3_pkg::LEN_OFFSET) begin
               nb      = (gap6 > 6'd8) ? 4'd8 : gap6[3:0];
               fill_in = fill_ff + {2'b0, nb};
            end else begin
               nb       = room7[3:0];
               fill_in  = '0;
               state_in = ST_COMP;
               start_in = 1'b1;
               ret_in   = ST_PAD;
            end
         end
         ST_COMP: begin
            if (comp_stat.done) begin
               cv_in    = comp_cv;
               state_in = ret_ff;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               digest_in    = cv_ff;
               cv_in        = sm3_pkg::IV;
               total_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      block_in = sm3_pkg::blk_append(block_ff, src, nb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         rem_ff       <= '0;
         last_ff      <= 1'b0;
         cv_ff        <= sm3_pkg::IV;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         last_ff      <= last_in;
         cv_ff        <= cv_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      block_ff  <= block_in;
      pend_ff   <= pend_in;
      digest_ff <= digest_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digest_0 = digest_ff[255:192];
   assign rsp_digest_1 = digest_ff[191:128];
   assign rsp_digest_2 = digest_ff[127:64];
   assign rsp_digest_3 = digest_ff[63:0];

   `SM3_ASSERT_IMPL(a_comp_only_in_comp, comp_stat.busy, state_ff == ST_COMP, "round unit busy outside compress")
   `SM3_ASSERT_IMPL(a_emit_restarts, $rose(rsp_valid_ff), fill_ff == 6'd0 && total_ff == 61'd0 && cv_ff == sm3_pkg::IV, "hasher not restarted after digest")
   `SM3_ASSERT_NEXT(a_last_finalizes, req_valid && !req_stall && req_last, state_ff != ST_IDLE, "last transfer did not start padding")

endmodule
